// File: hw/rtl/mtfc_pkg.sv
// ----------------------------------------------------------------------------
// mtfc_pkg
// Shared types and constants for the move-to-front codec: list size,
// symbol codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package mtfc_pkg;

  localparam int unsigned LIST_LEN = 27;
  localparam int unsigned POS_W    = $clog2(LIST_LEN);

  localparam logic [7:0] SYM_DOLLAR = 8'h24;
  localparam logic [7:0] SYM_A      = 8'h61;
  localparam logic [7:0] SYM_Z      = 8'h7A;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef logic [7:0]          sym_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [LIST_LEN-1:0] cell_mask_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch request, restore list on start flag
    logic look;     // compare cells and register the match vector
    logic move;     // emit result and rotate the list
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_room; // output register can take a result this cycle
  } status_t;

  // list contents after reset: '$' then 'a' through 'z'
  function automatic sym_t initial_symbol(int unsigned k);
    sym_t sym;
    if (k == 0) begin
      sym = SYM_DOLLAR;
    end else begin
      sym = 8'(SYM_A + 8'(k - 1));
    end
    return sym;
  endfunction

endpackage

// File: hw/rtl/mtfc_ctrl.sv
// ----------------------------------------------------------------------------
// mtfc_ctrl
// Sequencer for one request at a time: capture, look up, then move to
// front and hand the result to the output register.
// ----------------------------------------------------------------------------
module mtfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mtfc_pkg::status_t status,
  output mtfc_pkg::cmd_t    cmd
);
  import mtfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOVE
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          if (status.out_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // input side only takes a request while idle
  assign in_stall = (state != ST_IDLE);

  // datapath commands
  always_comb begin
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.look    = (state == ST_LOOK);
    cmd.move    = (state == ST_MOVE) && status.out_room;
  end

endmodule

// File: hw/rtl/mtfc_datapath.sv
// ----------------------------------------------------------------------------
// mtfc_datapath
// Symbol list cells, direction register, parallel compare, rotate to
// front and the output register.
// ----------------------------------------------------------------------------
module mtfc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_direction,
  input  logic [7:0]         in_value,
  input  logic               start_of_text,
  input  mtfc_pkg::cmd_t     cmd,
  output mtfc_pkg::status_t  status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_value
);
  import mtfc_pkg::*;

  sym_t       cells [LIST_LEN];
  logic       direction;
  sym_t       value_q;
  cell_mask_t match;
  cell_mask_t match_q;
  logic       found_q;
  cell_mask_t shift_en;
  pos_t       hit_pos;
  sym_t       hit_sym;

  // direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_valid) begin
      direction <= cfg_direction;
    end
  end

  // request value register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_q <= in_value;
    end
  end

  // compare all cells at once; decode picks the cell by position
  always_comb begin
    for (int i = 0; i < LIST_LEN; i++) begin
      if (direction == DIR_DECODE) begin
        match[i] = (value_q == 8'(i));
      end else begin
        match[i] = (cells[i] == value_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      match_q <= match;
      found_q <= |match;
    end
  end

  // list entries are distinct, so the match vector has at most one bit set
  always_comb begin
    hit_pos = '0;
    hit_sym = '0;
    for (int i = 0; i < LIST_LEN; i++) begin
      hit_pos = hit_pos | (match_q[i] ? POS_W'(i) : '0);
      hit_sym = hit_sym | (match_q[i] ? cells[i] : '0);
    end
  end

  // cells at or before the hit take their neighbor's symbol
  always_comb begin
    shift_en[0] = 1'b0;
    for (int i = 1; i < LIST_LEN; i++) begin
      shift_en[i] = |(match_q >> i);
    end
  end

  // list cells: restore on start flag, rotate hit to front on move
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIST_LEN; i++) begin
        cells[i] <= initial_symbol(i);
      end
    end else if (cmd.capture && start_of_text) begin
      for (int i = 0; i < LIST_LEN; i++) begin
        cells[i] <= initial_symbol(i);
      end
    end else if (cmd.move && found_q) begin
      cells[0] <= hit_sym;
      for (int i = 1; i < LIST_LEN; i++) begin
        if (shift_en[i]) begin
          cells[i] <= cells[i-1];
        end
      end
    end
  end

  // output register
  assign status.out_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.move && found_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move && found_q) begin
      out_value <= (direction == DIR_DECODE) ? hit_sym : 8'(hit_pos);
    end
  end

endmodule

// File: hw/rtl/move_to_front_codec_unit.sv
// ----------------------------------------------------------------------------
// move_to_front_codec_unit
// Move-to-front coder over the list '$', 'a'..'z' with encode and decode.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_direction) sets the mode:
//   0 encodes symbol bytes to positions, 1 decodes positions to symbols.
//   Write it only while no request is in flight; cfg_ready is always high.
//   Input channel (in_valid/in_stall) carries in_value and start_of_text;
//   start_of_text restores the initial list before the request is handled.
//   Output channel (out_valid/out_stall) carries out_value. A symbol not in
//   the list, or a position of 27 or more, produces no result and leaves
//   the list as it is.
//   The sequencer takes one request at a time through capture, compare and
//   rotate, and the rotate step registers the result; a stalled result holds
//   the rotate step until the output register frees up, and the input
//   stalls meanwhile.
//   Reset loads the initial list, clears direction to encode and empties
//   the output register.
// ----------------------------------------------------------------------------
module move_to_front_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       start_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value
);
  import mtfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  mtfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // list and result datapath
  mtfc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_direction (cfg_direction),
    .in_value      (in_value),
    .start_of_text (start_of_text),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value)
  );

endmodule
